/* hw/rtl/mie_pkg.sv */
// Shared types and constants for the modular inverse block.
// Used by mie_ctrl, mie_dp and modular_inverse_ext_euclid; depends on nothing.
package mie_pkg;

  localparam int unsigned MIE_VALUE_WIDTH_DEF = 32;
  localparam logic [63:0] MIE_RESET_MODULUS   = 64'd100000009;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } mie_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // take a new operand, seed the coefficients
    logic div_init;  // start a division of rem_hi by rem_lo
    logic div_step;  // one quotient bit
    logic update;    // rotate remainders and coefficients
    logic finish;    // fold sign and capture the result
  } mie_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rem_lo_zero;
  } mie_sts_t;

endpackage

/* hw/rtl/mie_dp.sv */
// Datapath: modulus register, remainder and coefficient pair, bit-serial divider
// with shift-add product, and the result register. Depends on mie_pkg.
module mie_dp import mie_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = MIE_VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [VALUE_WIDTH-1:0] cfg_modulus,
  input  logic [VALUE_WIDTH-1:0] in_operand,
  input  mie_cmd_t               cmd,
  output mie_sts_t               sts,
  output logic [VALUE_WIDTH-1:0] out_inverse
);

  localparam int unsigned CW = VALUE_WIDTH + 1;

  logic [VALUE_WIDTH-1:0] modulus_r;
  logic [VALUE_WIDTH-1:0] rem_hi_r, rem_lo_r;
  logic [VALUE_WIDTH-1:0] part_r, dq_r;
  logic [VALUE_WIDTH-1:0] inverse_r;
  logic [CW-1:0]          coef_cur_r, coef_next_r, prod_r;

  logic [VALUE_WIDTH:0]   shifted, diff;
  logic                   qbit;
  logic [VALUE_WIDTH-1:0] part_nxt;
  logic [CW-1:0]          prod_nxt;
  logic [CW-1:0]          coef_fixed;
  logic [VALUE_WIDTH-1:0] inverse_nxt;

  // restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    shifted  = {part_r, dq_r[VALUE_WIDTH-1]};
    diff     = shifted - {1'b0, rem_lo_r};
    qbit     = (shifted >= {1'b0, rem_lo_r});
    part_nxt = qbit ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
    // q * coef_next built alongside the quotient bits, modulo 2^CW
    prod_nxt = {prod_r[CW-2:0], 1'b0} + (qbit ? coef_next_r : '0);
  end

  // pull a negative coefficient into range
  always_comb begin
    coef_fixed  = coef_cur_r + {1'b0, modulus_r};
    inverse_nxt = coef_cur_r[CW-1] ? coef_fixed[VALUE_WIDTH-1:0]
                                   : coef_cur_r[VALUE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= VALUE_WIDTH'(MIE_RESET_MODULUS);
    end else if (cfg_valid) begin
      modulus_r <= cfg_modulus;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_hi_r    <= in_operand;
      rem_lo_r    <= modulus_r;
      coef_cur_r  <= CW'(1);
      coef_next_r <= '0;
    end
    if (cmd.div_init) begin
      part_r <= '0;
      dq_r   <= rem_hi_r;
      prod_r <= '0;
    end
    if (cmd.div_step) begin
      part_r <= part_nxt;
      dq_r   <= {dq_r[VALUE_WIDTH-2:0], qbit};
      prod_r <= prod_nxt;
    end
    if (cmd.update) begin
      rem_hi_r    <= rem_lo_r;
      rem_lo_r    <= part_r;
      coef_cur_r  <= coef_next_r;
      coef_next_r <= coef_cur_r - prod_r;
    end
    if (cmd.finish) begin
      inverse_r <= inverse_nxt;
    end
  end

  assign sts.rem_lo_zero = (rem_lo_r == '0);
  assign out_inverse     = inverse_r;

  // the running remainder always stays below the divisor
  a_part_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> part_r < rem_lo_r)
    else $error("partial remainder not below divisor");

  // a division only starts on a nonzero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |-> !sts.rem_lo_zero)
    else $error("division started with zero divisor");

endmodule

/* hw/rtl/mie_ctrl.sv */
// Controller: sequences load, the Euclid steps and the result capture,
// and owns the input ready and output valid. Depends on mie_pkg.
module mie_ctrl import mie_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = MIE_VALUE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  mie_sts_t sts,
  output mie_cmd_t cmd
);

  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  mie_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.rem_lo_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_WIDTH - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_TEST;
      end
      ST_FINISH: begin
        // hold until the output slot is free
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_accept_to_test: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_TEST)
    else $error("accepted beat did not start a step");

  a_div_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_init |=> state_r == ST_DIV && cnt_r == '0)
    else $error("division entered with stale bit count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r || out_ready)
    else $error("result register overwritten before taken");

endmodule

/* hw/rtl/modular_inverse_ext_euclid.sv */
// Top level of the modular inverse block (extended Euclid, bit-serial divide).
// Instantiates mie_ctrl and mie_dp; depends on mie_pkg.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready   cfg_modulus
//   in       in         in_valid  / in_ready    in_operand
//   out      out        out_valid / out_ready   out_inverse
//
// From accept to result an item runs the Euclid steps; each step tests the
// divisor, divides with the restoring divider (one quotient bit per cycle)
// and rotates the remainders and coefficients. A zero divisor leads to finish.
// One item is worked at a time; the next is accepted once the result sits in
// the output register. A stalled output holds the result and, once the next
// item is done, holds the controller. Synchronous active-low reset; the
// modulus resets to 100000009 and may be written at any idle time.
module modular_inverse_ext_euclid import mie_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = MIE_VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [VALUE_WIDTH-1:0] cfg_modulus,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_operand,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_inverse
);

  mie_cmd_t cmd;
  mie_sts_t sts;

  assign cfg_ready = 1'b1;

  mie_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mie_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_modulus (cfg_modulus),
    .in_operand  (in_operand),
    .cmd         (cmd),
    .sts         (sts),
    .out_inverse (out_inverse)
  );

endmodule
